// ===== hw/rtl/lca_pkg.sv =====
// shared types, codes and sizing constants for the lowest common ancestor engine
`timescale 1ns / 1ps

package lca_pkg;

    localparam int NODE_W              = 10;
    localparam int DEPTH_W             = 11;
    localparam int DEFAULT_MAX_NODES   = 1024;
    localparam int DEFAULT_JUMP_LEVELS = 11;

    localparam logic [NODE_W-1:0]  ROOT_RESET = NODE_W'(1);
    localparam logic [DEPTH_W-1:0] DEPTH_SAT  = {DEPTH_W{1'b1}};

    // request opcodes
    localparam logic OPC_ATTACH = 1'b0;
    localparam logic OPC_QUERY  = 1'b1;

    // datapath operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_LOAD      = 4'd1;
    localparam t_op OP_RED       = 4'd2;
    localparam t_op OP_KCLR      = 4'd3;
    localparam t_op OP_ROOT_WR   = 4'd4;
    localparam t_op OP_ATT_START = 4'd5;
    localparam t_op OP_ATT_DEPTH = 4'd6;
    localparam t_op OP_ATT_LVL   = 4'd7;
    localparam t_op OP_Q_RDA     = 4'd8;
    localparam t_op OP_Q_RDB     = 4'd9;
    localparam t_op OP_Q_SWAP    = 4'd10;
    localparam t_op OP_LIFT_D    = 4'd11;
    localparam t_op OP_LIFT_C    = 4'd12;
    localparam t_op OP_P2_START  = 4'd13;
    localparam t_op OP_P2_STEP   = 4'd14;

    typedef struct packed {
        t_op  op;
        logic out_load;
        logic out_from_u;
    } t_cmd;

    typedef struct packed {
        logic opcode;
        logic is_root;
        logic red_done;
        logic k_zero;
        logic k_last;
        logic eq_uv;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/lca_ctrl.sv =====
// sequencing state machine for attach and query requests
`timescale 1ns / 1ps

module lca_ctrl #(
    parameter int JUMP_LEVELS = lca_pkg::DEFAULT_JUMP_LEVELS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lca_pkg::t_sts i_sts,
    output lca_pkg::t_cmd o_cmd
);
    import lca_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RED     = 4'd1;
    localparam logic [3:0] S_ROOT    = 4'd2;
    localparam logic [3:0] S_ATT0    = 4'd3;
    localparam logic [3:0] S_ATT_DEP = 4'd4;
    localparam logic [3:0] S_ATT_LVL = 4'd5;
    localparam logic [3:0] S_QDA     = 4'd6;
    localparam logic [3:0] S_QDB     = 4'd7;
    localparam logic [3:0] S_QSW     = 4'd8;
    localparam logic [3:0] S_LIFT_D  = 4'd9;
    localparam logic [3:0] S_LIFT_C  = 4'd10;
    localparam logic [3:0] S_MEET    = 4'd11;
    localparam logic [3:0] S_P2      = 4'd12;
    localparam logic [3:0] S_FIN_J   = 4'd13;
    localparam logic [3:0] S_FIN_U   = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd.op         = OP_NONE;
        o_cmd.out_load   = 1'b0;
        o_cmd.out_from_u = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_RED;
                end
            end
            S_RED: begin
                if (!i_sts.red_done) begin
                    o_cmd.op = OP_RED;
                end else begin
                    o_cmd.op = OP_KCLR;
                    if (i_sts.opcode == OPC_QUERY) begin
                        n_state = S_QDA;
                    end else if (i_sts.is_root) begin
                        n_state = S_ROOT;
                    end else begin
                        n_state = S_ATT0;
                    end
                end
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT_WR;
                if (i_sts.k_last) n_state = S_IDLE;
            end
            S_ATT0: begin
                o_cmd.op = OP_ATT_START;
                n_state  = S_ATT_DEP;
            end
            S_ATT_DEP: begin
                o_cmd.op = OP_ATT_DEPTH;
                n_state  = (JUMP_LEVELS == 1) ? S_IDLE : S_ATT_LVL;
            end
            S_ATT_LVL: begin
                o_cmd.op = OP_ATT_LVL;
                if (i_sts.k_last) n_state = S_IDLE;
            end
            S_QDA: begin
                o_cmd.op = OP_Q_RDA;
                n_state  = S_QDB;
            end
            S_QDB: begin
                o_cmd.op = OP_Q_RDB;
                n_state  = S_QSW;
            end
            S_QSW: begin
                o_cmd.op = OP_Q_SWAP;
                n_state  = S_LIFT_D;
            end
            S_LIFT_D: begin
                o_cmd.op = OP_LIFT_D;
                n_state  = S_LIFT_C;
            end
            S_LIFT_C: begin
                o_cmd.op = OP_LIFT_C;
                n_state  = i_sts.k_zero ? S_MEET : S_LIFT_D;
            end
            S_MEET: begin
                if (i_sts.eq_uv) begin
                    n_state = S_FIN_U;
                end else begin
                    o_cmd.op = OP_P2_START;
                    n_state  = S_P2;
                end
            end
            S_P2: begin
                o_cmd.op = OP_P2_STEP;
                if (i_sts.k_zero) n_state = S_FIN_J;
            end
            S_FIN_J: begin
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_FIN_U: begin
                o_cmd.out_load   = i_sts.out_free;
                o_cmd.out_from_u = 1'b1;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/lca_dpath.sv =====
// datapath: index reduction, jump and depth memories, lifting registers, result register
`timescale 1ns / 1ps

module lca_dpath #(
    parameter int MAX_NODES   = lca_pkg::DEFAULT_MAX_NODES,
    parameter int JUMP_LEVELS = lca_pkg::DEFAULT_JUMP_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lca_pkg::t_cmd               i_cmd,
    output lca_pkg::t_sts               o_sts,
    input  logic                        i_opcode,
    input  logic [lca_pkg::NODE_W-1:0]  i_node_a,
    input  logic [lca_pkg::NODE_W-1:0]  i_node_b,
    input  logic [lca_pkg::NODE_W-1:0]  i_root_node,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [lca_pkg::NODE_W-1:0]  o_ancestor_node
);
    import lca_pkg::*;

    localparam int NW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LW     = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int KW     = $clog2(JUMP_LEVELS + 1);
    localparam int AW     = NW + LW;
    localparam int JDEPTH = MAX_NODES << LW;
    localparam int RW     = NODE_W + 1;
    // steps of shift-subtract reduction so that port indices wrap into range
    localparam int RED_STEPS = (MAX_NODES >= (1 << NODE_W)) ? 0
                                 : (NODE_W + 1 - $clog2(MAX_NODES + 1));
    localparam int RCW    = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;

    localparam logic [KW-1:0] KTOP   = KW'(JUMP_LEVELS - 1);
    localparam logic [LW-1:0] KTOP_L = LW'(JUMP_LEVELS - 1);

    // memories
    logic [NW-1:0]      jump_mem  [0:JDEPTH-1];
    logic [DEPTH_W-1:0] depth_mem [0:MAX_NODES-1];

    logic               jw_en, ja_en, jb_en;
    logic [AW-1:0]      jw_addr, ja_addr, jb_addr;
    logic [NW-1:0]      jw_data;
    logic [NW-1:0]      r_qa, r_qb, r_bypd;
    logic               r_byp;
    logic [NW-1:0]      jq_a, jq_b;

    logic               dw_en, dr_en;
    logic [NW-1:0]      dw_addr, dr_addr;
    logic [DEPTH_W-1:0] dw_data;
    logic [DEPTH_W-1:0] r_dq;

    // working registers
    logic               r_opc, n_opc;
    logic [NODE_W-1:0]  r_a, n_a, r_b, n_b, r_rt, n_rt;
    logic [RCW-1:0]     r_rc, n_rc;
    logic [KW-1:0]      r_k, n_k;
    logic [NW-1:0]      r_u, n_u, r_v, n_v;
    logic [DEPTH_W-1:0] r_du, n_du, r_da, n_da;
    logic               r_ov, n_ov;
    logic [NODE_W-1:0]  r_on, n_on;

    logic [RW-1:0]      red_div;
    logic [NW-1:0]      w_a, w_b, w_rt;
    logic               k_zero;
    logic [KW-1:0]      km1;
    logic [LW-1:0]      k_lvl, km1_lvl;
    logic [NW-1:0]      lift_v, p2_u, p2_v;
    logic               p2_diff, q_swap;
    logic               out_free;

    always_ff @(posedge i_clk) begin
        if (jw_en) jump_mem[jw_addr] <= jw_data;
        if (ja_en) begin
            r_qa   <= jump_mem[ja_addr];
            r_bypd <= jw_data;
        end
        if (jb_en) r_qb <= jump_mem[jb_addr];
    end

    // write-first forwarding on port a for a level that points back at itself
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (ja_en) begin
            r_byp <= jw_en && (jw_addr == ja_addr);
        end
    end

    assign jq_a = r_byp ? r_bypd : r_qa;
    assign jq_b = r_qb;

    always_ff @(posedge i_clk) begin
        if (dw_en) depth_mem[dw_addr] <= dw_data;
        if (dr_en) r_dq <= depth_mem[dr_addr];
    end

    assign red_div  = RW'(64'(MAX_NODES) << (r_rc - RCW'(1)));
    assign w_a      = NW'(r_a);
    assign w_b      = NW'(r_b);
    assign w_rt     = NW'(r_rt);
    assign k_zero   = (r_k == '0);
    assign km1      = k_zero ? '0 : (r_k - KW'(1));
    assign k_lvl    = r_k[LW-1:0];
    assign km1_lvl  = km1[LW-1:0];
    assign lift_v   = (r_dq >= r_du) ? jq_a : r_v;
    assign p2_diff  = (jq_a != jq_b);
    assign p2_u     = p2_diff ? jq_a : r_u;
    assign p2_v     = p2_diff ? jq_b : r_v;
    assign q_swap   = (r_da > r_dq);
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        n_opc   = r_opc;
        n_a     = r_a;
        n_b     = r_b;
        n_rt    = r_rt;
        n_rc    = r_rc;
        n_k     = r_k;
        n_u     = r_u;
        n_v     = r_v;
        n_du    = r_du;
        n_da    = r_da;
        jw_en   = 1'b0;
        jw_addr = '0;
        jw_data = '0;
        ja_en   = 1'b0;
        ja_addr = '0;
        jb_en   = 1'b0;
        jb_addr = '0;
        dw_en   = 1'b0;
        dw_addr = '0;
        dw_data = '0;
        dr_en   = 1'b0;
        dr_addr = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                n_opc = i_opcode;
                n_a   = i_node_a;
                n_b   = i_node_b;
                n_rt  = i_root_node;
                n_rc  = RCW'(RED_STEPS);
            end
            OP_RED: begin
                if ({1'b0, r_a} >= red_div) n_a = NODE_W'({1'b0, r_a} - red_div);
                if ({1'b0, r_b} >= red_div) n_b = NODE_W'({1'b0, r_b} - red_div);
                if ({1'b0, r_rt} >= red_div) n_rt = NODE_W'({1'b0, r_rt} - red_div);
                n_rc = r_rc - RCW'(1);
            end
            OP_KCLR: begin
                n_k = '0;
            end
            OP_ROOT_WR: begin
                jw_en   = 1'b1;
                jw_addr = {w_a, k_lvl};
                jw_data = w_a;
                dw_en   = k_zero;
                dw_addr = w_a;
                dw_data = DEPTH_W'(1);
                n_k     = r_k + KW'(1);
            end
            OP_ATT_START: begin
                jw_en   = 1'b1;
                jw_addr = {w_a, LW'(0)};
                jw_data = w_b;
                ja_en   = 1'b1;
                ja_addr = {w_b, LW'(0)};
                dr_en   = 1'b1;
                dr_addr = w_b;
                n_k     = KW'(1);
            end
            OP_ATT_DEPTH: begin
                dw_en   = 1'b1;
                dw_addr = w_a;
                dw_data = (r_dq == DEPTH_SAT) ? DEPTH_SAT : (r_dq + DEPTH_W'(1));
            end
            OP_ATT_LVL: begin
                jw_en   = 1'b1;
                jw_addr = {w_a, k_lvl};
                jw_data = jq_a;
                ja_en   = 1'b1;
                ja_addr = {jq_a, k_lvl};
                n_k     = r_k + KW'(1);
            end
            OP_Q_RDA: begin
                dr_en   = 1'b1;
                dr_addr = w_a;
            end
            OP_Q_RDB: begin
                dr_en   = 1'b1;
                dr_addr = w_b;
                n_da    = r_dq;
            end
            OP_Q_SWAP: begin
                // u is the shallower node, v gets lifted
                if (q_swap) begin
                    n_u  = w_b;
                    n_v  = w_a;
                    n_du = r_dq;
                end else begin
                    n_u  = w_a;
                    n_v  = w_b;
                    n_du = r_da;
                end
                ja_en   = 1'b1;
                ja_addr = {(q_swap ? w_a : w_b), KTOP_L};
                n_k     = KTOP;
            end
            OP_LIFT_D: begin
                dr_en   = 1'b1;
                dr_addr = jq_a;
            end
            OP_LIFT_C: begin
                n_v = lift_v;
                if (!k_zero) begin
                    ja_en   = 1'b1;
                    ja_addr = {lift_v, km1_lvl};
                    n_k     = km1;
                end
            end
            OP_P2_START: begin
                ja_en   = 1'b1;
                ja_addr = {r_u, KTOP_L};
                jb_en   = 1'b1;
                jb_addr = {r_v, KTOP_L};
                n_k     = KTOP;
            end
            OP_P2_STEP: begin
                n_u     = p2_u;
                n_v     = p2_v;
                ja_en   = 1'b1;
                ja_addr = {p2_u, km1_lvl};
                jb_en   = !k_zero;
                jb_addr = {p2_v, km1_lvl};
                n_k     = km1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        n_on = r_on;
        if (i_cmd.out_load) begin
            n_ov = 1'b1;
            n_on = i_cmd.out_from_u ? NODE_W'(r_u) : NODE_W'(jq_a);
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_rc <= '0;
            r_k  <= '0;
        end else begin
            r_ov <= n_ov;
            r_rc <= n_rc;
            r_k  <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opc <= n_opc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rt  <= n_rt;
        r_u   <= n_u;
        r_v   <= n_v;
        r_du  <= n_du;
        r_da  <= n_da;
        r_on  <= n_on;
    end

    assign o_sts.opcode   = r_opc;
    assign o_sts.is_root  = (w_a == w_rt);
    assign o_sts.red_done = (r_rc == '0);
    assign o_sts.k_zero   = k_zero;
    assign o_sts.k_last   = (r_k == KTOP);
    assign o_sts.eq_uv    = (r_u == r_v);
    assign o_sts.out_free = out_free;

    assign o_out_valid     = r_ov;
    assign o_ancestor_node = r_on;

endmodule

// ===== hw/rtl/lowest_common_ancestor_core.sv =====
// top level of the binary lifting lowest common ancestor engine, one request at a time
// attach: writes the depth and every jump level of the node; no result
// query: lifting does one jump read then one depth read per level; the joint lift
//   is skipped when lifting alone meets; below 1024 nodes every request first runs
//   shift-subtract index reduction steps; a request is taken only in idle
// reset: synchronous, active low; clears control, root_node back to 1; tables not cleared
`timescale 1ns / 1ps

module lowest_common_ancestor_core #(
    parameter int MAX_NODES   = lca_pkg::DEFAULT_MAX_NODES,
    parameter int JUMP_LEVELS = lca_pkg::DEFAULT_JUMP_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [lca_pkg::NODE_W-1:0]  i_node_a,
    input  logic [lca_pkg::NODE_W-1:0]  i_node_b,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lca_pkg::NODE_W-1:0]  o_ancestor_node,
    // root_node register
    input  logic                        i_cfg_we,
    input  logic [lca_pkg::NODE_W-1:0]  i_cfg_wdata
);
    import lca_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic [NODE_W-1:0] r_root_node;

    // root index, the user must write it only while idle (the block does not enforce it); captured with each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_node <= ROOT_RESET;
        end else if (i_cfg_we) begin
            r_root_node <= i_cfg_wdata;
        end
    end

    // sequencer: walks index reduction, attach fill, depth lift and joint lift
    lca_ctrl #(
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: jump table, depth table and the result register
    lca_dpath #(
        .MAX_NODES   (MAX_NODES),
        .JUMP_LEVELS (JUMP_LEVELS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_node_a        (i_node_a),
        .i_node_b        (i_node_b),
        .i_root_node     (r_root_node),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_ancestor_node (o_ancestor_node)
    );

endmodule

// ===== bench/lca_scoreboard_pkg.sv =====
// scoreboard class: binary lifting tree predictor and queue of expected ancestors
`timescale 1ns / 1ps

package lca_scoreboard_pkg;

    import lca_pkg::*;

    localparam int NODES  = DEFAULT_MAX_NODES;
    localparam int LEVELS = DEFAULT_JUMP_LEVELS;

    class ancestor_scoreboard;

        bit [NODE_W-1:0]  hop [NODES][LEVELS];
        bit [DEPTH_W-1:0] depth [NODES];
        bit [NODE_W-1:0]  root;
        bit [NODE_W-1:0]  ancestor_due [$];
        int unsigned      mismatches;

        function new();
            for (int n = 0; n < NODES; n++) begin
                depth[n] = '0;
                for (int k = 0; k < LEVELS; k++) hop[n][k] = '0;
            end
            root       = ROOT_RESET;
            mismatches = 0;
        endfunction

        function void set_root(bit [NODE_W-1:0] value);
            root = value;
        endfunction

        function int pending();
            return ancestor_due.size();
        endfunction

        function void place_node(bit [NODE_W-1:0] node, bit [NODE_W-1:0] parent);
            bit [DEPTH_W:0] next_depth;
            if (node == root) begin
                depth[node] = 1;
                for (int k = 0; k < LEVELS; k++) hop[node][k] = node;
            end else begin
                next_depth  = {1'b0, depth[parent]} + 1'b1;
                depth[node] = (next_depth > DEPTH_SAT) ? DEPTH_SAT : next_depth[DEPTH_W-1:0];
                hop[node][0] = parent;
                for (int k = 1; k < LEVELS; k++) hop[node][k] = hop[hop[node][k-1]][k-1];
            end
        endfunction

        function bit [NODE_W-1:0] common_ancestor(bit [NODE_W-1:0] a, bit [NODE_W-1:0] b);
            bit [NODE_W-1:0] u, v, t, pu, pv;
            u = a;
            v = b;
            if (depth[u] > depth[v]) begin
                t = u;
                u = v;
                v = t;
            end
            for (int k = LEVELS - 1; k >= 0; k--) begin
                pv = hop[v][k];
                if (depth[pv] >= depth[u]) v = pv;
            end
            if (u == v) return u;
            for (int k = LEVELS - 1; k >= 0; k--) begin
                pu = hop[u][k];
                pv = hop[v][k];
                if (pu != pv) begin
                    u = pu;
                    v = pv;
                end
            end
            return hop[u][0];
        endfunction

        function void note_request(bit op, bit [NODE_W-1:0] a, bit [NODE_W-1:0] b);
            if (op == OPC_ATTACH) place_node(a, b);
            else ancestor_due.insert(ancestor_due.size(), common_ancestor(a, b));
        endfunction

        function void check_result(bit [NODE_W-1:0] got);
            bit [NODE_W-1:0] want;
            if (ancestor_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result ancestor_node=%0d", $time, got);
            end else begin
                want = ancestor_due.pop_front();
                if (got != want) begin
                    mismatches++;
                    $display("%0t: ancestor_node mismatch expected=%0d actual=%0d",
                             $time, want, got);
                end
            end
        endfunction

    endclass

endpackage

// ===== bench/tb_lowest_common_ancestor_core.sv =====
// testbench top for the lowest common ancestor engine
`timescale 1ns / 1ps

module tb_lowest_common_ancestor_core;

    import lca_pkg::*;
    import lca_scoreboard_pkg::*;

    // generous bound on the whole run for the watchdog
    localparam int CYCLE_LIMIT  = 1_000_000;
    // longer than the slowest request (a full query) so the core is surely idle
    localparam int DRAIN_CYCLES = 3 * DEFAULT_JUMP_LEVELS + 20;
    localparam int RANDOM_ITEMS = 130;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_opcode = OPC_ATTACH;
    logic [NODE_W-1:0] in_node_a = '0;
    logic [NODE_W-1:0] in_node_b = '0;
    logic              out_ready = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [NODE_W-1:0] cfg_wdata = '0;
    wire               o_in_ready;
    wire               o_out_valid;
    wire  [NODE_W-1:0] o_ancestor_node;

    ancestor_scoreboard lca_sb = new();

    // stimulus bookkeeping: nodes whose table rows have been written at least once
    bit [NODE_W-1:0] placed [$];
    bit              is_placed [NODES];
    bit [NODE_W-1:0] last_placed;
    bit [NODE_W-1:0] cur_root     = ROOT_RESET;
    bit [NODE_W-1:0] chain_tail;
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     cycle_count   = 0;

    lowest_common_ancestor_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (in_opcode),
        .i_node_a        (in_node_a),
        .i_node_b        (in_node_b),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_ancestor_node (o_ancestor_node),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check what was taken at this edge, then pick next ready at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) lca_sb.check_result(o_ancestor_node);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // offer one request, hold it until taken, then hand it to the predictor
    // valid is left high on return, so back-to-back requests drop it only for random idling
    task automatic send_request(input logic op, input logic [NODE_W-1:0] a,
                                input logic [NODE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_node_a <= a;
        in_node_b <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        lca_sb.note_request(op, a, b);
        if (op == OPC_ATTACH) begin
            if (!is_placed[a]) begin
                is_placed[a] = 1'b1;
                placed.insert(placed.size(), a);
            end
            last_placed = a;
        end
    endtask

    // drop valid, wait for every expected result, then let any attach finish
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (lca_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // new root is written only after settling to idle; the root row is written right after
    task automatic write_root(input logic [NODE_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        lca_sb.set_root(value);
        cur_root = value;
        send_request(OPC_ATTACH, value, NODE_W'($urandom_range(0, NODES - 1)));
    endtask

    function automatic bit [NODE_W-1:0] pick_placed();
        return placed[$urandom_range(0, placed.size() - 1)];
    endfunction

    // mostly tree growth and queries on written nodes, some re-attach noise
    task automatic random_phase(input int count);
        int unsigned     sel;
        bit [NODE_W-1:0] a, b;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                // bias parent toward the newest node so the tree gets deep
                b = ($urandom_range(0, 99) < 60) ? last_placed : pick_placed();
                a = NODE_W'($urandom_range(0, NODES - 1));
                send_request(OPC_ATTACH, a, b);
            end else if (sel < 90) begin
                a = pick_placed();
                b = ($urandom_range(0, 99) < 10) ? a : pick_placed();
                send_request(OPC_QUERY, a, b);
            end else if (sel < 95) begin
                // self attach: node becomes its own parent one level deeper
                a = pick_placed();
                send_request(OPC_ATTACH, a, a);
            end else begin
                // root attach again, parent field is don't-care
                send_request(OPC_ATTACH, cur_root, NODE_W'($urandom_range(0, NODES - 1)));
            end
        end
    endtask

    // one long chain through every other node, in random order
    task automatic build_chain();
        bit [NODE_W-1:0] order [$];
        bit [NODE_W-1:0] swap;
        bit [NODE_W-1:0] prev;
        int              j;
        for (int n = 0; n < NODES; n++) if (n != cur_root) order.insert(order.size(), NODE_W'(n));
        for (int n = order.size() - 1; n > 0; n--) begin
            j        = $urandom_range(0, n);
            swap     = order[n];
            order[n] = order[j];
            order[j] = swap;
        end
        prev = cur_root;
        foreach (order[n]) begin
            send_request(OPC_ATTACH, order[n], prev);
            prev = order[n];
        end
        chain_tail = prev;
    endtask

    initial begin
        send_idle_pct = 35;
        recv_idle_pct = 47;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, root still at its reset value of one
        send_request(OPC_ATTACH, 10'd1, 10'd1023);     // root attach ignores parent
        send_request(OPC_QUERY, 10'd1, 10'd1);
        send_request(OPC_ATTACH, 10'd0, 10'd1);
        send_request(OPC_ATTACH, 10'd1023, 10'd0);
        send_request(OPC_ATTACH, 10'd512, 10'd1023);
        send_request(OPC_ATTACH, 10'd341, 10'd1);
        send_request(OPC_ATTACH, 10'd682, 10'd341);
        send_request(OPC_ATTACH, 10'd1022, 10'd682);
        send_request(OPC_QUERY, 10'd1023, 10'd682);    // meets at the root
        send_request(OPC_QUERY, 10'd512, 10'd0);       // deeper node first
        send_request(OPC_QUERY, 10'd0, 10'd512);       // deeper node second
        send_request(OPC_QUERY, 10'd1022, 10'd341);    // lifting alone meets
        send_request(OPC_QUERY, 10'd512, 10'd512);
        send_request(OPC_QUERY, 10'd1022, 10'd512);
        send_request(OPC_ATTACH, 10'd341, 10'd341);    // self attach of a non-root node
        send_request(OPC_QUERY, 10'd682, 10'd341);
        send_request(OPC_QUERY, 10'd1022, 10'd0);
        send_request(OPC_ATTACH, 10'd1, 10'd512);      // root attach again
        send_request(OPC_QUERY, 10'd1023, 10'd341);
        send_request(OPC_QUERY, 10'd1, 10'd682);

        // root at the low extreme
        write_root(10'd0);
        random_phase(RANDOM_ITEMS);

        // swap idling, root at the high extreme
        send_idle_pct = 47;
        recv_idle_pct = 35;
        write_root(10'd1023);
        random_phase(RANDOM_ITEMS);

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_root(NODE_W'($urandom_range(2, NODES - 2)));
        random_phase(RANDOM_ITEMS);

        // deep tree through every node, then queries from its far end
        write_root(10'd1);
        build_chain();
        for (int i = 0; i < 30; i++) send_request(OPC_QUERY, chain_tail, pick_placed());
        random_phase(RANDOM_ITEMS);
        for (int i = 0; i < 20; i++) begin
            send_request(OPC_QUERY, chain_tail, pick_placed());
            send_request(OPC_QUERY, pick_placed(), chain_tail);
        end

        settle();
        if (lca_sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
